// ===== hdl/metadata_event_update_formatter_core_defines.svh =====
// Assertion macros shared by the metadata event update formatter.
`ifndef METADATA_EVENT_UPDATE_FORMATTER_CORE_DEFINES_SVH
`define METADATA_EVENT_UPDATE_FORMATTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MEUF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MEUF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/meuf_pkg.sv =====
// Package: types, constants and codes of the metadata event update formatter.
`timescale 1ns / 1ps
package meuf_pkg;

   localparam int DEVICE_BITS_DEF = 8;
   localparam int DEV_FIELD_BITS  = 12;
   localparam int TOF_BITS        = 21;
   localparam int PROD_BITS       = 28;
   localparam int NORM_STEPS      = 4;
   localparam int NORM_CNT_BITS   = $clog2(NORM_STEPS);

   localparam logic [PROD_BITS-1:0] TOF_SCALE   = PROD_BITS'(100);
   localparam logic [31:0]          NS_PER_SEC  = 32'd1000000000;
   localparam logic [3:0]           TYPE_TRIGGER = 4'h5;
   localparam logic [3:0]           TYPE_ANALOG  = 4'h6;

   localparam logic [2:0] STATUS_EVENT_KNOWN   = 3'd0;
   localparam logic [2:0] STATUS_EVENT_UNKNOWN = 3'd1;
   localparam logic [2:0] STATUS_WRITE_OK      = 3'd2;
   localparam logic [2:0] STATUS_DUPLICATE     = 3'd3;
   localparam logic [2:0] STATUS_OUT_OF_RANGE  = 3'd4;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVENT = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_ADD,
      ST_NORM,
      ST_FINISH
   } meuf_state_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic lookup;
      logic add;
      logic norm;
      logic finish;
   } meuf_cmd_type;

   typedef struct packed {
      logic clear_last;
   } meuf_status_type;

endpackage

// ===== hdl/meuf_ctrl.sv =====
// Controller: sequences table clear, lookup, time normalization and result handoff.
`timescale 1ns / 1ps
module meuf_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  meuf_pkg::meuf_status_type status,
   output meuf_pkg::meuf_cmd_type    cmd
);
   import meuf_pkg::*;

   localparam logic [NORM_CNT_BITS-1:0] NORM_LAST = NORM_CNT_BITS'(NORM_STEPS - 1);

   meuf_state_type             state_ff, state_in;
   logic [NORM_CNT_BITS-1:0]   norm_cnt_ff, norm_cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (status.clear_last) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_ADD;
         ST_ADD:    state_in = ST_NORM;
         ST_NORM:   if (norm_cnt_ff == NORM_LAST) state_in = ST_FINISH;
         ST_FINISH: if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd         = '0;
      req_ready   = 1'b0;
      norm_cnt_in = '0;
      unique case (state_ff)
         ST_CLEAR:  cmd.clear = 1'b1;
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_LOOKUP: cmd.lookup = 1'b1;
         ST_ADD:    cmd.add = 1'b1;
         ST_NORM: begin
            cmd.norm    = 1'b1;
            norm_cnt_in = norm_cnt_ff + 1'b1;
         end
         ST_FINISH: cmd.finish = slot_free;
         default:   cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         norm_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         norm_cnt_ff  <= norm_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/meuf_datapath.sv =====
// Datapath: request registers, key table memories, timestamp arithmetic, result registers.
`timescale 1ns / 1ps
module meuf_datapath #(
   parameter int DEVICE_BITS = meuf_pkg::DEVICE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  meuf_pkg::meuf_cmd_type    cmd,
   output meuf_pkg::meuf_status_type status,
   input  logic                      req_opcode,
   input  logic [63:0]               req_pulse_time,
   input  logic [31:0]               req_pixel,
   input  logic [31:0]               req_tof,
   input  logic                      req_entry_is_adc,
   input  logic [11:0]               req_entry_device_number,
   input  logic [31:0]               req_entry_device_id,
   input  logic [31:0]               req_entry_variable_id,
   input  logic                      req_entry_persist,
   output logic [2:0]                rsp_status,
   output logic [31:0]               rsp_stamp_seconds,
   output logic [29:0]               rsp_stamp_nanoseconds,
   output logic [31:0]               rsp_device_id,
   output logic [31:0]               rsp_variable_id,
   output logic [15:0]               rsp_update_value,
   output logic                      rsp_persistent
);
   import meuf_pkg::*;

   localparam int TABLE_DEPTH = 2 << DEVICE_BITS;
   localparam int ADDR_BITS   = DEVICE_BITS + 1;

   // request registers
   logic                   opcode_ff;
   logic [63:0]            pulse_ff;
   logic [31:0]            pixel_ff;
   logic [TOF_BITS-1:0]    tof_ff;
   logic                   adc_ff;
   logic [11:0]            dev_ff;
   logic [31:0]            dev_id_ff;
   logic [31:0]            var_id_ff;
   logic                   persist_ff;

   // table
   logic [63:0]            ids_mem   [TABLE_DEPTH];
   logic [1:0]             flags_mem [TABLE_DEPTH];
   logic [63:0]            ids_rd_ff;
   logic [1:0]             flags_rd_ff;
   logic [ADDR_BITS-1:0]   clr_addr_ff;

   // arithmetic
   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   logic [31:0]            ns_ff, ns_in;
   logic [31:0]            sec_ff, sec_in;

   logic [ADDR_BITS-1:0]   wr_idx, ev_idx, rd_addr;
   logic [DEV_FIELD_BITS:0] wr_dev_ext, ev_dev_ext;
   logic [3:0]             ev_type;
   logic                   wr_range_bad, ev_key_ok, known, commit;

   assign ev_type    = pixel_ff[31:28];
   assign wr_dev_ext = {1'b0, dev_ff};
   assign ev_dev_ext = {1'b0, pixel_ff[27:16]};
   assign wr_range_bad = (wr_dev_ext >> DEVICE_BITS) != '0;
   assign ev_key_ok  = ((ev_type == TYPE_TRIGGER) || (ev_type == TYPE_ANALOG))
                       && ((ev_dev_ext >> DEVICE_BITS) == '0);
   assign wr_idx  = {adc_ff, dev_ff[DEVICE_BITS-1:0]};
   assign ev_idx  = {ev_type == TYPE_ANALOG, pixel_ff[16 +: DEVICE_BITS]};
   assign rd_addr = (opcode_ff == OP_EVENT) ? ev_idx : wr_idx;
   assign known   = ev_key_ok && flags_rd_ff[1];
   assign commit  = cmd.finish && (opcode_ff == OP_WRITE) && !wr_range_bad && !flags_rd_ff[1];

   assign status.clear_last = &clr_addr_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         opcode_ff  <= req_opcode;
         pulse_ff   <= req_pulse_time;
         pixel_ff   <= req_pixel;
         tof_ff     <= req_tof[TOF_BITS-1:0];
         adc_ff     <= req_entry_is_adc;
         dev_ff     <= req_entry_device_number;
         dev_id_ff  <= req_entry_device_id;
         var_id_ff  <= req_entry_variable_id;
         persist_ff <= req_entry_persist;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         flags_mem[clr_addr_ff] <= '0;
      end else if (commit) begin
         flags_mem[rd_addr] <= {1'b1, persist_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         ids_mem[rd_addr] <= {dev_id_ff, var_id_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         ids_rd_ff   <= ids_mem[rd_addr];
         flags_rd_ff <= flags_mem[rd_addr];
      end
   end

   always_comb begin
      prod_in = PROD_BITS'(tof_ff) * TOF_SCALE;
      ns_in   = ns_ff;
      sec_in  = sec_ff;
      if (cmd.add) begin
         ns_in  = 32'(prod_ff) + pulse_ff[31:0];
         sec_in = pulse_ff[63:32];
      end else if (cmd.norm && (ns_ff >= NS_PER_SEC)) begin
         ns_in  = ns_ff - NS_PER_SEC;
         sec_in = sec_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         prod_ff <= prod_in;
      end
      ns_ff  <= ns_in;
      sec_ff <= sec_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (opcode_ff == OP_EVENT) begin
            rsp_status            <= known ? STATUS_EVENT_KNOWN : STATUS_EVENT_UNKNOWN;
            rsp_stamp_seconds     <= sec_ff;
            rsp_stamp_nanoseconds <= ns_ff[29:0];
            rsp_device_id         <= known ? ids_rd_ff[63:32] : '0;
            rsp_variable_id       <= known ? ids_rd_ff[31:0] : '0;
            rsp_update_value      <= pixel_ff[15:0];
            rsp_persistent        <= known && flags_rd_ff[0];
         end else begin
            priority if (wr_range_bad) begin
               rsp_status <= STATUS_OUT_OF_RANGE;
            end else if (flags_rd_ff[1]) begin
               rsp_status <= STATUS_DUPLICATE;
            end else begin
               rsp_status <= STATUS_WRITE_OK;
            end
            rsp_stamp_seconds     <= '0;
            rsp_stamp_nanoseconds <= '0;
            rsp_device_id         <= '0;
            rsp_variable_id       <= '0;
            rsp_update_value      <= '0;
            rsp_persistent        <= 1'b0;
         end
      end
   end

endmodule

// ===== hdl/metadata_event_update_formatter_core.sv =====
// Top level of the metadata event update formatter: controller, datapath and checks.
//
// Request channel (req_*): opcode 1 formats one detector event into a variable
// update; opcode 0 writes one entry of the key table (type 5/6, device number).
// Response channel (rsp_*): exactly one response per request, in request order.
// Both channels use valid/ready; a transfer happens when both are high.
// One request is in flight at a time, paced by the four single-step
// nanosecond normalization passes and the one-port table read.
// The response sits in an output register, so the next request is taken
// while an earlier response still waits; a stalled receiver holds the
// block in its final step only once that register is full as well.
// Reset: synchronous, active high. After reset the flag table is cleared
// one entry per cycle, all 2 << DEVICE_BITS entries (512 by default), with
// req_ready low for the whole pass.
`timescale 1ns / 1ps
`include "metadata_event_update_formatter_core_defines.svh"
module metadata_event_update_formatter_core #(
   parameter int DEVICE_BITS = meuf_pkg::DEVICE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [63:0] req_pulse_time,
   input  logic [31:0] req_pixel,
   input  logic [31:0] req_tof,
   input  logic        req_entry_is_adc,
   input  logic [11:0] req_entry_device_number,
   input  logic [31:0] req_entry_device_id,
   input  logic [31:0] req_entry_variable_id,
   input  logic        req_entry_persist,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_stamp_seconds,
   output logic [29:0] rsp_stamp_nanoseconds,
   output logic [31:0] rsp_device_id,
   output logic [31:0] rsp_variable_id,
   output logic [15:0] rsp_update_value,
   output logic        rsp_persistent
);
   import meuf_pkg::*;

   meuf_cmd_type    cmd;
   meuf_status_type status;

   meuf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   meuf_datapath #(
      .DEVICE_BITS (DEVICE_BITS)
   ) u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .req_opcode              (req_opcode),
      .req_pulse_time          (req_pulse_time),
      .req_pixel               (req_pixel),
      .req_tof                 (req_tof),
      .req_entry_is_adc        (req_entry_is_adc),
      .req_entry_device_number (req_entry_device_number),
      .req_entry_device_id     (req_entry_device_id),
      .req_entry_variable_id   (req_entry_variable_id),
      .req_entry_persist       (req_entry_persist),
      .rsp_status              (rsp_status),
      .rsp_stamp_seconds       (rsp_stamp_seconds),
      .rsp_stamp_nanoseconds   (rsp_stamp_nanoseconds),
      .rsp_device_id           (rsp_device_id),
      .rsp_variable_id         (rsp_variable_id),
      .rsp_update_value        (rsp_update_value),
      .rsp_persistent          (rsp_persistent)
   );

   `MEUF_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "request taken while another is in flight")
   `MEUF_ASSERT_NOW(a_status_range, clock, reset, rsp_valid, (rsp_status == STATUS_EVENT_KNOWN) || (rsp_status == STATUS_EVENT_UNKNOWN) || (rsp_status == STATUS_WRITE_OK) || (rsp_status == STATUS_DUPLICATE) || (rsp_status == STATUS_OUT_OF_RANGE), "response status code out of range")
   `MEUF_ASSERT_NOW(a_unknown_zero, clock, reset, rsp_valid && (rsp_status != STATUS_EVENT_KNOWN), (rsp_device_id == '0) && (rsp_variable_id == '0) && !rsp_persistent, "unknown key or write response carries table data")
   `MEUF_ASSERT_NOW(a_ns_normalized, clock, reset, rsp_valid, rsp_stamp_nanoseconds < 30'd1000000000, "nanoseconds not normalized")

endmodule

// ===== test/metadata_event_update_formatter_core_test.sv =====
// Self-checking testbench of the metadata event update formatter: directed table, then random requests.
`timescale 1ns / 1ps
module metadata_event_update_formatter_core_test;
   import meuf_pkg::*;

   localparam int DEVICE_BITS    = DEVICE_BITS_DEF;
   localparam int TABLE_DEPTH    = 2 << DEVICE_BITS;
   localparam int DEVICE_LIMIT   = 1 << DEVICE_BITS;
   localparam int RANDOM_ITEMS   = 900;
   localparam int CALM_ITEMS     = 120;
   localparam int DRAIN_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct {
      logic        opcode;
      logic [63:0] pulse_time;
      logic [31:0] pixel;
      logic [31:0] tof;
      logic        is_adc;
      logic [11:0] dev_num;
      logic [31:0] dev_id;
      logic [31:0] var_id;
      logic        persist;
   } request_type;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] seconds;
      logic [29:0] nanos;
      logic [31:0] device_id;
      logic [31:0] variable_id;
      logic [15:0] value;
      logic        persistent;
   } update_type;

   typedef struct {
      request_type req;
      bit          typed;
      update_type  result;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_opcode;
   logic [63:0] req_pulse_time;
   logic [31:0] req_pixel;
   logic [31:0] req_tof;
   logic        req_entry_is_adc;
   logic [11:0] req_entry_device_number;
   logic [31:0] req_entry_device_id;
   logic [31:0] req_entry_variable_id;
   logic        req_entry_persist;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_stamp_seconds;
   logic [29:0] rsp_stamp_nanoseconds;
   logic [31:0] rsp_device_id;
   logic [31:0] rsp_variable_id;
   logic [15:0] rsp_update_value;
   logic        rsp_persistent;

   logic [63:0]  key_ids [TABLE_DEPTH];
   bit           key_valid [TABLE_DEPTH];
   bit           key_persist [TABLE_DEPTH];
   update_type   expected_updates [$];
   stim_row_type directed_rows [$];
   int           error_count = 0;
   int           idle_cycles = 0;
   int           stall_left = 0;
   bit           calm = 0;

   metadata_event_update_formatter_core dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_opcode              (req_opcode),
      .req_pulse_time          (req_pulse_time),
      .req_pixel               (req_pixel),
      .req_tof                 (req_tof),
      .req_entry_is_adc        (req_entry_is_adc),
      .req_entry_device_number (req_entry_device_number),
      .req_entry_device_id     (req_entry_device_id),
      .req_entry_variable_id   (req_entry_variable_id),
      .req_entry_persist       (req_entry_persist),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_status              (rsp_status),
      .rsp_stamp_seconds       (rsp_stamp_seconds),
      .rsp_stamp_nanoseconds   (rsp_stamp_nanoseconds),
      .rsp_device_id           (rsp_device_id),
      .rsp_variable_id         (rsp_variable_id),
      .rsp_update_value        (rsp_update_value),
      .rsp_persistent          (rsp_persistent)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic update_type format_update(input request_type r);
      update_type             u;
      logic [31:0]            sec;
      logic [31:0]            ns;
      logic [3:0]             kind;
      logic [11:0]            devn;
      logic [DEVICE_BITS:0]   idx;
      u = '{default: '0};
      if (r.opcode == OP_WRITE) begin
         idx = {r.is_adc, r.dev_num[DEVICE_BITS-1:0]};
         if (r.dev_num >= DEVICE_LIMIT) begin
            u.status = STATUS_OUT_OF_RANGE;
         end else if (key_valid[idx]) begin
            u.status = STATUS_DUPLICATE;
         end else begin
            key_ids[idx] = {r.dev_id, r.var_id};
            key_valid[idx] = 1'b1;
            key_persist[idx] = r.persist;
            u.status = STATUS_WRITE_OK;
         end
      end else begin
         sec = r.pulse_time[63:32];
         ns = {11'b0, r.tof[TOF_BITS-1:0]} * 32'd100 + r.pulse_time[31:0];
         repeat (NORM_STEPS) begin
            if (ns >= NS_PER_SEC) begin
               ns = ns - NS_PER_SEC;
               sec = sec + 32'd1;
            end
         end
         kind = r.pixel[31:28];
         devn = r.pixel[27:16];
         u.status = STATUS_EVENT_UNKNOWN;
         if ((kind == TYPE_TRIGGER || kind == TYPE_ANALOG) && devn < DEVICE_LIMIT) begin
            idx = {kind == TYPE_ANALOG, devn[DEVICE_BITS-1:0]};
            if (key_valid[idx]) begin
               u.status = STATUS_EVENT_KNOWN;
               u.device_id = key_ids[idx][63:32];
               u.variable_id = key_ids[idx][31:0];
               u.persistent = key_persist[idx];
            end
         end
         u.seconds = sec;
         u.nanos = ns[29:0];
         u.value = r.pixel[15:0];
      end
      return u;
   endfunction

   // entry fields of an event carry noise; the block ignores them
   function automatic request_type make_event(input logic [63:0] pulse,
                                              input logic [31:0] pixel,
                                              input logic [31:0] tof);
      request_type r;
      r.opcode = OP_EVENT;
      r.pulse_time = pulse;
      r.pixel = pixel;
      r.tof = tof;
      r.is_adc = 1'($urandom_range(0, 1));
      r.dev_num = 12'($urandom_range(0, 4095));
      r.dev_id = $urandom;
      r.var_id = $urandom;
      r.persist = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic request_type make_write(input logic is_adc, input logic [11:0] devn,
                                              input logic [31:0] did, input logic [31:0] vid,
                                              input logic persist);
      request_type r;
      r.opcode = OP_WRITE;
      r.pulse_time = {$urandom, $urandom};
      r.pixel = $urandom;
      r.tof = $urandom;
      r.is_adc = is_adc;
      r.dev_num = devn;
      r.dev_id = did;
      r.var_id = vid;
      r.persist = persist;
      return r;
   endfunction

   function automatic update_type status_only(input logic [2:0] status);
      update_type u;
      u = '{default: '0};
      u.status = status;
      return u;
   endfunction

   function automatic update_type event_result(input logic [2:0] status, input logic [31:0] sec,
                                               input logic [29:0] ns, input logic [31:0] did,
                                               input logic [31:0] vid, input logic [15:0] val,
                                               input logic persist);
      update_type u;
      u.status = status;
      u.seconds = sec;
      u.nanos = ns;
      u.device_id = did;
      u.variable_id = vid;
      u.value = val;
      u.persistent = persist;
      return u;
   endfunction

   function automatic request_type random_request();
      request_type r;
      logic [11:0] devn;
      logic [63:0] pulse;
      logic [31:0] pixel;
      int          pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) devn = 12'($urandom_range(0, 23));
      else if (pick == 7) devn = 12'($urandom_range(DEVICE_LIMIT - 6, DEVICE_LIMIT - 1));
      else devn = 12'($urandom_range(0, 4095));
      if ($urandom_range(0, 9) < 3) begin
         r = make_write(1'($urandom_range(0, 1)), devn, $urandom, $urandom,
                        1'($urandom_range(0, 1)));
      end else begin
         pixel = $urandom;
         if ($urandom_range(0, 9) < 8) begin
            pixel[31:28] = $urandom_range(0, 1) ? TYPE_ANALOG : TYPE_TRIGGER;
            pixel[27:16] = devn;
         end
         pulse = {$urandom, $urandom};
         if ($urandom_range(0, 3) == 0) pulse[31:0] = NS_PER_SEC - 32'd2 + $urandom_range(0, 3);
         r = make_event(pulse, pixel, $urandom);
      end
      return r;
   endfunction

   task automatic send(input request_type r, input bit typed, input update_type result);
      update_type predicted;
      req_valid <= 1'b1;
      req_opcode <= r.opcode;
      req_pulse_time <= r.pulse_time;
      req_pixel <= r.pixel;
      req_tof <= r.tof;
      req_entry_is_adc <= r.is_adc;
      req_entry_device_number <= r.dev_num;
      req_entry_device_id <= r.dev_id;
      req_entry_variable_id <= r.var_id;
      req_entry_persist <= r.persist;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = format_update(r);
      expected_updates.push_back(typed ? result : predicted);
   endtask

   task automatic check_update();
      update_type e;
      if (expected_updates.size() == 0) begin
         $error("response with no request outstanding");
         error_count++;
      end else begin
         e = expected_updates.pop_front();
         if (rsp_status !== e.status) begin
            $error("rsp_status: expected %0d, got %0d", e.status, rsp_status);
            error_count++;
         end
         if (rsp_stamp_seconds !== e.seconds) begin
            $error("rsp_stamp_seconds: expected %0d, got %0d", e.seconds, rsp_stamp_seconds);
            error_count++;
         end
         if (rsp_stamp_nanoseconds !== e.nanos) begin
            $error("rsp_stamp_nanoseconds: expected %0d, got %0d", e.nanos,
                   rsp_stamp_nanoseconds);
            error_count++;
         end
         if (rsp_device_id !== e.device_id) begin
            $error("rsp_device_id: expected %h, got %h", e.device_id, rsp_device_id);
            error_count++;
         end
         if (rsp_variable_id !== e.variable_id) begin
            $error("rsp_variable_id: expected %h, got %h", e.variable_id, rsp_variable_id);
            error_count++;
         end
         if (rsp_update_value !== e.value) begin
            $error("rsp_update_value: expected %h, got %h", e.value, rsp_update_value);
            error_count++;
         end
         if (rsp_persistent !== e.persistent) begin
            $error("rsp_persistent: expected %0d, got %0d", e.persistent, rsp_persistent);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_update();
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 17);
      end else begin
         rsp_ready <= 1'b1;
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= OP_WRITE;
      req_pulse_time <= '0;
      req_pixel <= '0;
      req_tof <= '0;
      req_entry_is_adc <= 1'b0;
      req_entry_device_number <= '0;
      req_entry_device_id <= '0;
      req_entry_variable_id <= '0;
      req_entry_persist <= 1'b0;

      directed_rows.push_back('{make_event(64'd0, 32'h5000_0000, 32'd0), 1'b1,
         event_result(STATUS_EVENT_UNKNOWN, 32'd0, 30'd0, 32'd0, 32'd0, 16'd0, 1'b0)});
      directed_rows.push_back('{make_write(1'b0, 12'd0, 32'hffff_ffff, 32'hffff_ffff, 1'b1),
         1'b1, status_only(STATUS_WRITE_OK)});
      directed_rows.push_back('{make_write(1'b0, 12'd0, 32'd1, 32'd2, 1'b0), 1'b1,
         status_only(STATUS_DUPLICATE)});
      directed_rows.push_back('{make_write(1'b1, 12'd255, 32'h1234_5678, 32'h9abc_def0, 1'b0),
         1'b1, status_only(STATUS_WRITE_OK)});
      directed_rows.push_back('{make_write(1'b0, 12'd256, 32'd5, 32'd6, 1'b1), 1'b1,
         status_only(STATUS_OUT_OF_RANGE)});
      directed_rows.push_back('{make_write(1'b1, 12'd4095, 32'hffff_ffff, 32'hffff_ffff, 1'b1),
         1'b1, status_only(STATUS_OUT_OF_RANGE)});
      directed_rows.push_back('{make_event(64'd0, 32'h5000_ffff, 32'd0), 1'b1,
         event_result(STATUS_EVENT_KNOWN, 32'd0, 30'd0, 32'hffff_ffff, 32'hffff_ffff,
                      16'hffff, 1'b1)});
      directed_rows.push_back('{make_event(64'hffff_ffff_ffff_ffff, 32'h60ff_0000,
         32'hffff_ffff), 1'b0, status_only(STATUS_EVENT_KNOWN)});
      directed_rows.push_back('{make_event({32'd7, 32'd999999999}, 32'h0000_1234, 32'd0), 1'b1,
         event_result(STATUS_EVENT_UNKNOWN, 32'd7, 30'd999999999, 32'd0, 32'd0, 16'h1234,
                      1'b0)});
      directed_rows.push_back('{make_event({32'd7, 32'd1000000000}, 32'h7000_abcd, 32'd0), 1'b1,
         event_result(STATUS_EVENT_UNKNOWN, 32'd8, 30'd0, 32'd0, 32'd0, 16'habcd, 1'b0)});
      // tof bits above 20 are dropped
      directed_rows.push_back('{make_event(64'd0, 32'h5000_0001, 32'hffe0_0001), 1'b1,
         event_result(STATUS_EVENT_KNOWN, 32'd0, 30'd100, 32'hffff_ffff, 32'hffff_ffff,
                      16'h0001, 1'b1)});
      directed_rows.push_back('{make_event({$urandom, $urandom}, 32'h5100_0000, $urandom), 1'b0,
         status_only(STATUS_EVENT_UNKNOWN)});
      directed_rows.push_back('{make_event({$urandom, $urandom}, 32'h6000_0000, $urandom), 1'b0,
         status_only(STATUS_EVENT_UNKNOWN)});
      directed_rows.push_back('{make_write(1'b1, 12'd0, 32'h0000_0000, 32'h0000_0000, 1'b1),
         1'b1, status_only(STATUS_WRITE_OK)});
      directed_rows.push_back('{make_event({$urandom, $urandom}, 32'h6000_5a5a, $urandom), 1'b0,
         status_only(STATUS_EVENT_KNOWN)});
      directed_rows.push_back('{make_event({32'hffff_ffff, 32'hf000_0000}, 32'hffff_ffff,
         32'h001f_ffff), 1'b0, status_only(STATUS_EVENT_UNKNOWN)});
      directed_rows.push_back('{make_event({32'd5, 32'd3999999999}, 32'h60ff_0001, 32'd0), 1'b1,
         event_result(STATUS_EVENT_KNOWN, 32'd8, 30'd999999999, 32'h1234_5678, 32'h9abc_def0,
                      16'h0001, 1'b0)});
      directed_rows.push_back('{make_write(1'b0, 12'd255, 32'h8000_0001, 32'h0000_0001, 1'b0),
         1'b1, status_only(STATUS_WRITE_OK)});

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].result);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (expected_updates.size() != 0) @(posedge clock);
         end
         if (n >= RANDOM_ITEMS - CALM_ITEMS) begin
            calm = 1'b1;
         end else if ($urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         send(random_request(), 1'b0, status_only(STATUS_EVENT_KNOWN));
      end

      req_valid <= 1'b0;
      while (expected_updates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
